// ----- hdl/xfr_pkg.sv -----
package xfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int PLEN_W    = 6;
  localparam int TICK_W    = 10;
  localparam int STAT_W    = 3;
  localparam int OP_W      = 2;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_TIMEOUT  = 3'd1;
  localparam logic [STAT_W-1:0] ST_HEADER   = 3'd2;
  localparam logic [STAT_W-1:0] ST_LENGTH   = 3'd3;
  localparam logic [STAT_W-1:0] ST_CHECKSUM = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b1;

  localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'd79;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 10'd200;

  // header and length byte come before the payload
  localparam logic [PLEN_W:0] LEAD_BYTES = 7'd2;

  typedef enum logic [1:0] {
    RX_IDLE,
    RX_FRAME,
    RX_EMIT
  } rx_state_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] rx_byte;
    logic [PLEN_W-1:0] payload_length;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              data_valid;
    logic [STAT_W-1:0] status;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [PLEN_W-1:0] len;
    logic              out_free;
  } emit_req_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
  } emit_word_t;

endpackage

// ----- hdl/xfr_payload_buf.sv -----
module xfr_payload_buf #(
  parameter int MAX_PAYLOAD = 32,
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [xfr_pkg::BYTE_W-1:0] wr_data,
  input  xfr_pkg::emit_req_t       req,
  output xfr_pkg::emit_word_t      rd,
  output logic                     busy
);

  logic [xfr_pkg::BYTE_W-1:0] mem [MAX_PAYLOAD];

  logic                       run;
  logic                       pending;
  logic                       rd_last;
  logic [xfr_pkg::BYTE_W-1:0] rd_data;
  logic [xfr_pkg::PLEN_W-1:0] rd_idx;
  logic                       issue;
  logic                       last_addr;

  // one read in flight; the output slot is known free when its data lands
  assign issue     = run & ~pending & req.out_free;
  assign last_addr = (rd_idx + 6'd1) == req.len;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[rd_idx[AW-1:0]];
      rd_last <= last_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run     <= 1'b0;
      pending <= 1'b0;
      rd_idx  <= '0;
    end else begin
      pending <= issue;
      if (req.start) begin
        run    <= 1'b1;
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + 6'd1;
        if (last_addr) begin
          run <= 1'b0;
        end
      end
    end
  end

  assign rd.valid = pending;
  assign rd.data  = rd_data;
  assign rd.last  = rd_last;
  assign busy     = run | pending;

endmodule

// ----- hdl/xor_frame_receive_checker.sv -----
// Reply-frame receiver with XOR checksum check. A start word arms a frame with
// its payload length; byte words are counted, XOR-accumulated and the payload
// is written into a synchronous payload memory; tick words age the frame. A
// frame ends at payload length plus three bytes and yields either one status
// word (bad header, bad length, bad checksum, or ok with empty payload) or the
// payload bytes read back from the memory, last marked on the final one. A
// timeout yields one timeout status word. Start, byte and tick words are accepted
// while the output register drains. Payload readout keeps one read of the
// payload memory in flight and issues the next read only once the previous
// one has completed; input is stalled for the whole run.
// The payload memory needs no clearing after reset.
module xor_frame_receive_checker #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  xfr_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output xfr_pkg::out_word_t            out_data,
  input  logic                          cfg_write,
  input  logic [xfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xfr_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [xfr_pkg::PLEN_W-1:0] MAX_LEN = xfr_pkg::PLEN_W'(MAX_PAYLOAD);

  xfr_pkg::rx_state_t state, state_next;

  logic [xfr_pkg::BYTE_W-1:0] exp_header;
  logic [xfr_pkg::TICK_W-1:0] timeout_ticks;

  logic [xfr_pkg::PLEN_W-1:0] byte_count, byte_count_next;
  logic [xfr_pkg::PLEN_W-1:0] exp_len, exp_len_next;
  logic [xfr_pkg::BYTE_W-1:0] xor_acc, xor_acc_next;
  logic [xfr_pkg::TICK_W-1:0] elapsed, elapsed_next;
  logic                       hdr_ok, hdr_ok_next;
  logic                       len_ok, len_ok_next;

  logic                       in_accept;
  logic                       res_load;
  xfr_pkg::out_word_t         res_word;
  logic [xfr_pkg::TICK_W-1:0] tick_inc;
  logic [xfr_pkg::PLEN_W-1:0] store_idx;
  logic                       in_body;

  logic                       wr_en;
  xfr_pkg::emit_req_t         req;
  xfr_pkg::emit_word_t        rd;
  logic                       emit_busy;

  assign in_stall  = (state == xfr_pkg::RX_EMIT) | (out_valid & out_stall);
  assign in_accept = in_valid & ~in_stall;
  assign tick_inc  = elapsed + 10'd1;
  assign store_idx = byte_count - 6'd2;
  assign in_body   = {1'b0, byte_count} < ({1'b0, exp_len} + xfr_pkg::LEAD_BYTES);

  always_comb begin
    state_next      = state;
    byte_count_next = byte_count;
    exp_len_next    = exp_len;
    xor_acc_next    = xor_acc;
    elapsed_next    = elapsed;
    hdr_ok_next     = hdr_ok;
    len_ok_next     = len_ok;
    res_load        = 1'b0;
    res_word        = '{payload_byte: '0, data_valid: 1'b0,
                        status: xfr_pkg::ST_OK, last: 1'b1};
    wr_en           = 1'b0;
    req.start       = 1'b0;
    req.len         = exp_len;
    req.out_free    = ~out_valid | ~out_stall;

    case (state)
      xfr_pkg::RX_EMIT: begin
        if (!emit_busy) begin
          state_next = xfr_pkg::RX_IDLE;
        end
      end
      default: begin
        if (in_accept) begin
          if (in_data.operation == xfr_pkg::OP_START) begin
            state_next      = xfr_pkg::RX_FRAME;
            byte_count_next = '0;
            exp_len_next    = (in_data.payload_length > MAX_LEN) ? MAX_LEN
                                                                 : in_data.payload_length;
            xor_acc_next    = '0;
            elapsed_next    = '0;
            hdr_ok_next     = 1'b0;
            len_ok_next     = 1'b0;
          end else if (state == xfr_pkg::RX_FRAME) begin
            if (in_data.operation == xfr_pkg::OP_TICK) begin
              elapsed_next = tick_inc;
              if (tick_inc >= timeout_ticks) begin
                state_next      = xfr_pkg::RX_IDLE;
                res_load        = 1'b1;
                res_word.status = xfr_pkg::ST_TIMEOUT;
              end
            end else if (in_data.operation == xfr_pkg::OP_BYTE) begin
              if (in_body) begin
                if (byte_count == 6'd0) begin
                  hdr_ok_next = in_data.rx_byte == exp_header;
                end else if (byte_count == 6'd1) begin
                  len_ok_next = in_data.rx_byte == (xfr_pkg::BYTE_W'(exp_len) + 8'd1);
                end else begin
                  wr_en = 1'b1;
                end
                xor_acc_next    = xor_acc ^ in_data.rx_byte;
                byte_count_next = byte_count + 6'd1;
              end else begin
                // checksum byte closes the frame
                state_next = xfr_pkg::RX_IDLE;
                res_load   = 1'b1;
                if (!hdr_ok) begin
                  res_word.status = xfr_pkg::ST_HEADER;
                end else if (!len_ok) begin
                  res_word.status = xfr_pkg::ST_LENGTH;
                end else if (in_data.rx_byte != xor_acc) begin
                  res_word.status = xfr_pkg::ST_CHECKSUM;
                end else if (exp_len != 6'd0) begin
                  res_load   = 1'b0;
                  req.start  = 1'b1;
                  state_next = xfr_pkg::RX_EMIT;
                end
              end
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= xfr_pkg::RX_IDLE;
      byte_count    <= '0;
      exp_len       <= '0;
      xor_acc       <= '0;
      elapsed       <= '0;
      hdr_ok        <= 1'b0;
      len_ok        <= 1'b0;
      exp_header    <= xfr_pkg::HEADER_RESET;
      timeout_ticks <= xfr_pkg::TIMEOUT_RESET;
      out_valid     <= 1'b0;
    end else begin
      state      <= state_next;
      byte_count <= byte_count_next;
      exp_len    <= exp_len_next;
      xor_acc    <= xor_acc_next;
      elapsed    <= elapsed_next;
      hdr_ok     <= hdr_ok_next;
      len_ok     <= len_ok_next;
      if (cfg_write) begin
        case (cfg_index)
          xfr_pkg::REG_HEADER:  exp_header    <= cfg_data[xfr_pkg::BYTE_W-1:0];
          xfr_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data;
          default: ;
        endcase
      end
      if (res_load || rd.valid) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= res_word;
    end else if (rd.valid) begin
      out_data <= '{payload_byte: rd.data, data_valid: 1'b1,
                    status: xfr_pkg::ST_OK, last: rd.last};
    end
  end

  xfr_payload_buf #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_buf (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_addr(store_idx[AW-1:0]),
    .wr_data(in_data.rx_byte),
    .req    (req),
    .rd     (rd),
    .busy   (emit_busy)
  );

endmodule

// ----- hdl/xfr_checker.sv -----
module xfr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input xfr_pkg::out_word_t out_data
);

  // payload words always carry ok status
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.data_valid |-> out_data.status == xfr_pkg::ST_OK)
    else $error("payload word with non-ok status");

  // a word without payload ends the run
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.data_valid |-> out_data.last)
    else $error("status word without last");

  // hold off input until the payload run has ended
  a_run_holds_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> in_stall)
    else $error("input taken during payload run");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

endmodule

bind xor_frame_receive_checker xfr_checker u_xfr_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
